/* rtl/awpt_pkg.sv */
// ----------------------------------------------------------------------------
// awpt_pkg
// Shared types and constants for the address wait priority table.
// ----------------------------------------------------------------------------
package awpt_pkg;

	localparam int WAIT_SLOTS_DEF = 16;
	localparam int MAX_WAKES      = 16;
	localparam int WAKE_W         = $clog2(MAX_WAKES + 1);
	localparam logic [7:0] NO_PRIO_BOUND = 8'h80;

	typedef enum logic [1:0] {
		CMD_SIGNAL = 2'd0,
		CMD_WAIT   = 2'd1
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_READ_ERR = 2'd1,
		STS_BAD_CMD  = 2'd2,
		STS_FULL     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_OUT
	} state_t;

	// one stored waiter
	typedef struct packed {
		logic [31:0] addr;
		logic [7:0]  thread;
		logic [6:0]  prio;
	} entry_t;

	// sequencer to compare unit
	typedef struct packed {
		logic clear;
		logic cmp_en;
	} best_ctl_t;

	// compare unit to sequencer
	typedef struct packed {
		logic       found;
		logic [7:0] thread;
	} best_res_t;

endpackage

/* rtl/address_wait_priority_table.sv */
// ----------------------------------------------------------------------------
// address_wait_priority_table
// Table of threads waiting on addresses, released by priority on signal.
// ----------------------------------------------------------------------------
// Commands enter on the s_axis channel, one item at a time; s_axis_tready is
// high only while the block is idle. A wait item gives one result the cycle
// after it is accepted and appends the caller when it blocks. A signal item
// with a nonzero count scans the table once per released thread and once
// more, through the single compare unit, and closes up the table after
// each removal through the one memory port. The result for a released
// thread is shown once the next scan tells whether it is the last one.
// A signal releases at most 16 threads and always gives at least one result.
// Results leave on m_axis from an output register; while the receiver
// stalls, the sequencer holds and no new item is accepted.
// Reset empties the table at once through its fill count; stored entries
// are left as they are and are never read beyond the count.
// ----------------------------------------------------------------------------
module address_wait_priority_table
	import awpt_pkg::*;
#(
	parameter int WAIT_SLOTS = WAIT_SLOTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [31:0] target_address, [63:32] operand_value, [95:64] memory_word,
	// [96] read_ok, [104:97] caller_thread, [111:105] caller_priority
	input  logic [111:0] s_axis_tdata,
	// [1:0] command
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [1:0] status, [2] woken_valid, [10:3] woken_thread, [11] caller_blocked
	output logic [15:0]  m_axis_tdata,
	output logic         m_axis_tlast
);

	localparam int IDX_W = $clog2(WAIT_SLOTS);
	localparam int CNT_W = $clog2(WAIT_SLOTS + 1);

	// input fields
	logic [31:0] in_addr;
	logic [31:0] in_operand;
	logic [31:0] in_mem_word;
	logic        in_read_ok;
	logic [7:0]  in_thread;
	logic [6:0]  in_prio;
	logic [1:0]  in_cmd;

	assign in_addr     = s_axis_tdata[31:0];
	assign in_operand  = s_axis_tdata[63:32];
	assign in_mem_word = s_axis_tdata[95:64];
	assign in_read_ok  = s_axis_tdata[96];
	assign in_thread   = s_axis_tdata[104:97];
	assign in_prio     = s_axis_tdata[111:105];
	assign in_cmd      = s_axis_tuser;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  idx_q;
	logic              vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [31:0]       addr_q;
	logic [WAKE_W-1:0] limit_q;
	logic [WAKE_W-1:0] n_q;
	logic              pend_q;
	logic [7:0]        pend_thr_q;
	logic              ret_shift_q;
	logic [15:0]       out_data_q;
	logic              out_last_q;

	logic              accept;
	logic              issue;
	logic              drained;
	logic              more;
	logic              wait_gt;
	logic              tbl_full;
	logic [WAKE_W-1:0] limit_in;

	// memory and compare unit hookup
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	entry_t            mem_wdata;
	entry_t            mem_rdata;
	best_ctl_t         best_ctl;
	best_res_t         best_res;
	logic [IDX_W-1:0]  best_idx;

	// output register load
	logic              out_load;
	status_t           out_status;
	logic              out_wv;
	logic [7:0]        out_thr;
	logic              out_blk;
	logic              out_last;
	logic              out_ret_shift;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign issue    = idx_q < cnt_q;
	assign drained  = !issue && !vld_s1;
	assign more     = best_res.found && (n_q < limit_q);
	assign wait_gt  = $signed(in_operand) > $signed(in_mem_word);
	assign tbl_full = cnt_q == CNT_W'(WAIT_SLOTS);

	// negative or oversized counts wake up to the result limit
	always_comb begin
		if (in_operand[31] || (|in_operand[30:WAKE_W])
				|| (in_operand[WAKE_W-1:0] > WAKE_W'(MAX_WAKES))) begin
			limit_in = WAKE_W'(MAX_WAKES);
		end else begin
			limit_in = in_operand[WAKE_W-1:0];
		end
	end

	awpt_mem #(
		.DEPTH (WAIT_SLOTS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (mem_rdata)
	);

	awpt_best #(
		.DEPTH (WAIT_SLOTS)
	) u_best (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (best_ctl),
		.key_addr  (addr_q),
		.entry     (mem_rdata),
		.entry_idx (idx_s1),
		.res       (best_res),
		.best_idx  (best_idx)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if ((in_cmd == CMD_SIGNAL) && (limit_in != '0)) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_SCAN: begin
				if (drained) begin
					if (more && !pend_q) begin
						state_d = ST_SHIFT;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_SHIFT: begin
				if (drained) begin
					state_d = ST_SCAN;
				end
			end
			ST_OUT: begin
				if (m_axis_tready) begin
					state_d = ret_shift_q ? ST_SHIFT : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_axis_tready   = 1'b0;
		m_axis_tvalid   = 1'b0;
		mem_we          = 1'b0;
		mem_waddr       = idx_s1 - IDX_W'(1);
		mem_wdata       = mem_rdata;
		best_ctl.clear  = 1'b0;
		best_ctl.cmp_en = 1'b0;
		out_load        = 1'b0;
		out_status      = STS_OK;
		out_wv          = 1'b0;
		out_thr         = '0;
		out_blk         = 1'b0;
		out_last        = 1'b1;
		out_ret_shift   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready  = 1'b1;
				best_ctl.clear = 1'b1;
				out_load       = accept;
				if (in_cmd == CMD_WAIT) begin
					if (!in_read_ok) begin
						out_status = STS_READ_ERR;
					end else if (wait_gt && tbl_full) begin
						out_status = STS_FULL;
					end else if (wait_gt) begin
						out_blk   = 1'b1;
						mem_we    = accept;
						mem_waddr = cnt_q[IDX_W-1:0];
						mem_wdata = '{addr: in_addr, thread: in_thread, prio: in_prio};
					end
				end else if (in_cmd != CMD_SIGNAL) begin
					out_status = STS_BAD_CMD;
				end
			end
			ST_SCAN: begin
				best_ctl.cmp_en = vld_s1;
				if (drained && (pend_q || !more)) begin
					// show the previous wake, or the empty result
					out_load      = 1'b1;
					out_wv        = pend_q;
					out_thr       = pend_q ? pend_thr_q : 8'd0;
					out_last      = !more;
					out_ret_shift = more;
				end
			end
			ST_SHIFT: begin
				// move entry idx_s1 down one place
				mem_we = vld_s1;
				// restart the compare unit for the scan that follows
				best_ctl.clear = drained;
			end
			ST_OUT: begin
				m_axis_tvalid = 1'b1;
				// restart the compare unit before the next scan
				best_ctl.clear = m_axis_tready && !ret_shift_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			vld_s1      <= 1'b0;
			n_q         <= '0;
			pend_q      <= 1'b0;
			ret_shift_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) && issue;
			if (((state_q == ST_SCAN) || (state_q == ST_SHIFT)) && issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (out_load) begin
				ret_shift_q <= out_ret_shift;
			end
			unique case (state_q)
				ST_IDLE: begin
					idx_q  <= '0;
					n_q    <= '0;
					pend_q <= 1'b0;
					if (mem_we) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_SHIFT: begin
					if (drained) begin
						cnt_q  <= cnt_q - CNT_W'(1);
						n_q    <= n_q + WAKE_W'(1);
						pend_q <= 1'b1;
						idx_q  <= '0;
					end
				end
				default: ;
			endcase
			if ((state_d == ST_SHIFT) && (state_q != ST_SHIFT)) begin
				idx_q <= CNT_W'(best_idx) + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q  <= in_addr;
			limit_q <= limit_in;
		end
		if ((state_q == ST_SHIFT) && drained) begin
			pend_thr_q <= best_res.thread;
		end
		if (out_load) begin
			out_data_q <= {4'd0, out_blk, out_thr, out_wv, out_status};
			out_last_q <= out_last;
		end
		if (state_q != ST_SCAN && state_q != ST_SHIFT) begin
			idx_s1 <= '0;
		end else begin
			idx_s1 <= idx_q[IDX_W-1:0];
		end
	end

	assign m_axis_tdata = out_data_q;
	assign m_axis_tlast = out_last_q;

	// ------------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------------
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(WAIT_SLOTS))
		else $error("waiter count beyond table size");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input taken while a result is pending");

	a_shift_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) && drained |=> cnt_q == $past(cnt_q) - CNT_W'(1))
		else $error("removal did not shrink the table");

	a_wake_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (n_q <= limit_q))
		else $error("more wakes than requested");

endmodule

/* rtl/awpt_mem.sv */
// ----------------------------------------------------------------------------
// awpt_mem
// Waiter storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module awpt_mem
	import awpt_pkg::*;
#(
	parameter int DEPTH = WAIT_SLOTS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  entry_t                   wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output entry_t                   rdata
);

	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/awpt_best.sv */
// ----------------------------------------------------------------------------
// awpt_best
// Compare unit: tracks the most urgent waiter on one address over a scan.
// ----------------------------------------------------------------------------
module awpt_best
	import awpt_pkg::*;
#(
	parameter int DEPTH = WAIT_SLOTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  best_ctl_t                ctl,
	input  logic [31:0]              key_addr,
	input  entry_t                   entry,
	input  logic [$clog2(DEPTH)-1:0] entry_idx,
	output best_res_t                res,
	output logic [$clog2(DEPTH)-1:0] best_idx
);

	logic [7:0] bound_q;
	logic       found_q;
	logic [7:0] thread_q;
	logic [$clog2(DEPTH)-1:0] idx_q;
	logic       take;

	// ties go to the later entry, hence <=
	assign take = ctl.cmp_en && (entry.addr == key_addr) && ({1'b0, entry.prio} <= bound_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_q <= NO_PRIO_BOUND;
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			bound_q <= NO_PRIO_BOUND;
			found_q <= 1'b0;
		end else if (take) begin
			bound_q <= {1'b0, entry.prio};
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			thread_q <= entry.thread;
			idx_q    <= entry_idx;
		end
	end

	assign res.found  = found_q;
	assign res.thread = thread_q;
	assign best_idx   = idx_q;

endmodule
